FILE: rtl/core/irc_pkg.sv
// shared constants, types and state codes of the index range coalescer
`default_nettype none
package irc_pkg;

   localparam int INDEX_SPACE = 128;
   localparam int IDX_W       = 7;
   localparam int CNT_W       = 8;
   localparam int WORD_W      = 8;
   localparam int BIT_W       = $clog2(WORD_W);
   localparam int MAP_DEPTH   = (INDEX_SPACE + WORD_W - 1) / WORD_W;
   localparam int ADDR_W      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

   typedef enum logic [2:0] {
      IRC_IDLE,
      IRC_MARK,
      IRC_SCAN_RD,
      IRC_SCAN_LOAD,
      IRC_SCAN_BIT,
      IRC_FLUSH
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } map_rd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } map_wr_type;

endpackage
`default_nettype wire

FILE: rtl/core/irc_ifs.sv
// block and run channel interfaces
`default_nettype none
interface irc_req_if;
   import irc_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] block_start;
   logic [CNT_W-1:0] block_count;
   logic             final_block;

   modport source (output valid, block_start, block_count, final_block, input ready);
   modport sink   (input valid, block_start, block_count, final_block, output ready);
endinterface

interface irc_rsp_if;
   import irc_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] run_start;
   logic [CNT_W-1:0] run_count;
   logic             run_last;
   logic             set_empty;
   logic             range_clipped;

   modport source (output valid, run_start, run_count, run_last, set_empty, range_clipped,
                   input ready);
   modport sink   (input valid, run_start, run_count, run_last, set_empty, range_clipped,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/core/index_range_coalescer.sv
// index range coalescer: marks index blocks in a bitmap, then emits merged runs
//
// req_if carries one block per beat (start, count, final flag); rsp_if carries merged runs.
// A block beat is taken only while the block is idle. Marking walks the bitmap words the
// block touches, one read and one write-back per word, overlapped so that the read of
// each word runs beside the write-back of the word before it. After the last write-back
// the block returns to idle, or starts the scan if the block was final; a block with a
// count of zero marks nothing and goes the same way straight from idle.
// After a block flagged final the bitmap is scanned one index a cycle unless the output
// stalls: each 8-bit word is read and loaded, then scanned bit by bit; after the 16 words
// the open and held runs are flushed. Runs leave through an output register; a run
// is held back one step so the last one can carry run_last. A list covering nothing yields
// one beat with set_empty. range_clipped is repeated on every beat of a list.
// With a beat waiting and rsp_if.ready low the scan halts on the next run to emit; nothing
// is dropped. The bitmap valid bits and clip flag clear as the last run is registered.
// Reset is synchronous and leaves an empty bitmap and no pending beat.
`default_nettype none
module index_range_coalescer (
   input  wire      clock,
   input  wire      reset,
   irc_req_if.sink  req_if,
   irc_rsp_if.source rsp_if
);
   import irc_pkg::*;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [ADDR_W-1:0] rd_word_ff, rd_word_in, end_word_ff, end_word_in;
   logic [ADDR_W-1:0] wr_word_ff, wr_word_in;
   logic              rd_active_ff, rd_active_in, wr_pend_ff, wr_pend_in;
   logic              final_ff, final_in, clip_ff, clip_in;
   logic [ADDR_W-1:0] scan_word_ff, scan_word_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              in_run_ff, in_run_in, pend_ff, pend_in;
   logic [IDX_W-1:0]  cur_start_ff, cur_start_in, pend_start_ff, pend_start_in;
   logic [CNT_W-1:0]  cur_count_ff, cur_count_in, pend_count_ff, pend_count_in;
   logic              out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]  out_start_ff, out_start_in;
   logic [CNT_W-1:0]  out_count_ff, out_count_in;
   logic              out_last_ff, out_last_in, out_empty_ff, out_empty_in;
   logic              out_clip_ff, out_clip_in;

   map_rd_type        map_rd;
   map_wr_type        map_wr;
   logic [WORD_W-1:0] map_rd_data;
   logic              map_clear;

   logic              accept, slot_free, cur_bit;
   logic [IDX_W-1:0]  scan_idx;
   logic [IDX_W+1:0]  block_end;
   logic              block_clip, block_mark;

   function automatic logic [WORD_W-1:0] word_mask(input logic [ADDR_W-1:0] word,
                                                   input logic [IDX_W-1:0]  lo,
                                                   input logic [IDX_W-1:0]  hi);
      logic [WORD_W-1:0] mask;
      logic [IDX_W-1:0]  idx;
      mask = '0;
      for (int b = 0; b < WORD_W; b++) begin
         idx     = (IDX_W'(word) << BIT_W) | IDX_W'(b);
         mask[b] = (idx >= lo) && (idx <= hi);
      end
      return mask;
   endfunction

   irc_map_store u_map (
      .clock   (clock),
      .reset   (reset),
      .rd      (map_rd),
      .rd_data (map_rd_data),
      .wr      (map_wr),
      .clear   (map_clear)
   );

   assign req_if.ready = (state_ff == IRC_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign slot_free    = !out_valid_ff || rsp_if.ready;

   assign block_end  = {2'b00, req_if.block_start} + {1'b0, req_if.block_count}
                       - (IDX_W+2)'(1);
   assign block_clip = (req_if.block_count != '0) && (block_end >= (IDX_W+2)'(INDEX_SPACE));
   assign block_mark = (req_if.block_count != '0)
                       && ({1'b0, req_if.block_start} < (IDX_W+1)'(INDEX_SPACE));

   assign cur_bit  = word_ff[bit_ff];
   assign scan_idx = (IDX_W'(scan_word_ff) << BIT_W) | IDX_W'(bit_ff);

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rd_word_in    = rd_word_ff;
      end_word_in   = end_word_ff;
      wr_word_in    = wr_word_ff;
      rd_active_in  = rd_active_ff;
      wr_pend_in    = 1'b0;
      final_in      = final_ff;
      clip_in       = clip_ff;
      scan_word_in  = scan_word_ff;
      bit_in        = bit_ff;
      word_in       = word_ff;
      in_run_in     = in_run_ff;
      pend_in       = pend_ff;
      cur_start_in  = cur_start_ff;
      cur_count_in  = cur_count_ff;
      pend_start_in = pend_start_ff;
      pend_count_in = pend_count_ff;
      out_valid_in  = out_valid_ff && !rsp_if.ready;
      out_start_in  = out_start_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      out_empty_in  = out_empty_ff;
      out_clip_in   = out_clip_ff;
      map_rd        = '0;
      map_wr        = '0;
      map_clear     = 1'b0;

      case (state_ff)
         IRC_IDLE: begin
            if (accept) begin
               final_in    = req_if.final_block;
               clip_in     = clip_ff || block_clip;
               lo_in       = req_if.block_start;
               hi_in       = block_clip ? IDX_W'(INDEX_SPACE - 1) : block_end[IDX_W-1:0];
               rd_word_in  = req_if.block_start[BIT_W +: ADDR_W];
               end_word_in = hi_in[BIT_W +: ADDR_W];
               scan_word_in = '0;
               if (block_mark) begin
                  rd_active_in = 1'b1;
                  state_in     = IRC_MARK;
               end else if (req_if.final_block) begin
                  state_in = IRC_SCAN_RD;
               end
            end
         end
         IRC_MARK: begin
            // read of word n overlaps write-back of word n-1
            if (wr_pend_ff) begin
               map_wr.en   = 1'b1;
               map_wr.addr = wr_word_ff;
               map_wr.data = map_rd_data | word_mask(wr_word_ff, lo_ff, hi_ff);
            end
            if (rd_active_ff) begin
               map_rd.en    = 1'b1;
               map_rd.addr  = rd_word_ff;
               wr_pend_in   = 1'b1;
               wr_word_in   = rd_word_ff;
               rd_active_in = (rd_word_ff != end_word_ff);
               rd_word_in   = rd_word_ff + ADDR_W'(1);
            end else if (!wr_pend_ff) begin
               state_in = final_ff ? IRC_SCAN_RD : IRC_IDLE;
            end
         end
         IRC_SCAN_RD: begin
            map_rd.en   = 1'b1;
            map_rd.addr = scan_word_ff;
            state_in    = IRC_SCAN_LOAD;
         end
         IRC_SCAN_LOAD: begin
            word_in  = map_rd_data;
            bit_in   = '0;
            state_in = IRC_SCAN_BIT;
         end
         IRC_SCAN_BIT: begin
            // halt only when a finished run must push out the held one and the slot is busy
            if (!(!cur_bit && in_run_ff && pend_ff && !slot_free)) begin
               if (cur_bit) begin
                  if (!in_run_ff) begin
                     in_run_in    = 1'b1;
                     cur_start_in = scan_idx;
                     cur_count_in = CNT_W'(1);
                  end else begin
                     cur_count_in = cur_count_ff + CNT_W'(1);
                  end
               end else if (in_run_ff) begin
                  if (pend_ff) begin
                     out_valid_in = 1'b1;
                     out_start_in = pend_start_ff;
                     out_count_in = pend_count_ff;
                     out_last_in  = 1'b0;
                     out_empty_in = 1'b0;
                     out_clip_in  = clip_ff;
                  end
                  pend_in       = 1'b1;
                  pend_start_in = cur_start_ff;
                  pend_count_in = cur_count_ff;
                  in_run_in     = 1'b0;
               end
               bit_in = bit_ff + BIT_W'(1);
               if (bit_ff == BIT_W'(WORD_W - 1)) begin
                  if (scan_word_ff == ADDR_W'(MAP_DEPTH - 1)) begin
                     state_in = IRC_FLUSH;
                  end else begin
                     scan_word_in = scan_word_ff + ADDR_W'(1);
                     state_in     = IRC_SCAN_RD;
                  end
               end
            end
         end
         IRC_FLUSH: begin
            if (in_run_ff) begin
               if (!pend_ff || slot_free) begin
                  if (pend_ff) begin
                     out_valid_in = 1'b1;
                     out_start_in = pend_start_ff;
                     out_count_in = pend_count_ff;
                     out_last_in  = 1'b0;
                     out_empty_in = 1'b0;
                     out_clip_in  = clip_ff;
                  end
                  pend_in       = 1'b1;
                  pend_start_in = cur_start_ff;
                  pend_count_in = cur_count_ff;
                  in_run_in     = 1'b0;
               end
            end else if (slot_free) begin
               out_valid_in = 1'b1;
               out_start_in = pend_ff ? pend_start_ff : '0;
               out_count_in = pend_ff ? pend_count_ff : '0;
               out_last_in  = 1'b1;
               out_empty_in = !pend_ff;
               out_clip_in  = clip_ff;
               pend_in      = 1'b0;
               clip_in      = 1'b0;
               map_clear    = 1'b1;
               state_in     = IRC_IDLE;
            end
         end
         default: begin
            state_in = IRC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IRC_IDLE;
         rd_active_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         final_ff     <= 1'b0;
         clip_ff      <= 1'b0;
         in_run_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_active_ff <= rd_active_in;
         wr_pend_ff   <= wr_pend_in;
         final_ff     <= final_in;
         clip_ff      <= clip_in;
         in_run_ff    <= in_run_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rd_word_ff    <= rd_word_in;
      end_word_ff   <= end_word_in;
      wr_word_ff    <= wr_word_in;
      scan_word_ff  <= scan_word_in;
      bit_ff        <= bit_in;
      word_ff       <= word_in;
      cur_start_ff  <= cur_start_in;
      cur_count_ff  <= cur_count_in;
      pend_start_ff <= pend_start_in;
      pend_count_ff <= pend_count_in;
      out_start_ff  <= out_start_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
      out_empty_ff  <= out_empty_in;
      out_clip_ff   <= out_clip_in;
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.run_start     = out_start_ff;
   assign rsp_if.run_count     = out_count_ff;
   assign rsp_if.run_last      = out_last_ff;
   assign rsp_if.set_empty     = out_empty_ff;
   assign rsp_if.range_clipped = out_clip_ff;

endmodule
`default_nettype wire

FILE: rtl/core/irc_map_store.sv
// word-wide coverage bitmap memory with per-word valid bits
`default_nettype none
module irc_map_store (
   input  wire                           clock,
   input  wire                           reset,
   input  irc_pkg::map_rd_type           rd,
   output logic [irc_pkg::WORD_W-1:0]    rd_data,
   input  irc_pkg::map_wr_type           wr,
   input  wire                           clear
);
   import irc_pkg::*;

   logic [WORD_W-1:0]    map_mem_ff [MAP_DEPTH];
   logic [MAP_DEPTH-1:0] valid_ff;
   logic [WORD_W-1:0]    rd_q_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         map_mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_q_ff <= map_mem_ff[rd.addr];
      end
   end

   // a word never written since the last clear reads as zero
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            rd_valid_ff <= valid_ff[rd.addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule
`default_nettype wire
